// ----- sv/packet_dedup_hash_cache_macros.svh -----
// Assertion macros shared by the duplicate-packet cache RTL.
`ifndef PACKET_DEDUP_HASH_CACHE_MACROS_SVH
`define PACKET_DEDUP_HASH_CACHE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PDHC_ASSERT_IMPL(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error("pdhc assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PDHC_ASSERT_NEXT(lbl, ant, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error("pdhc assertion failed");

`endif

// ----- sv/pdhc_pkg.sv -----
// Package with the hash constants, queue sizing and shared types.
package pdhc_pkg;

    localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
    localparam logic [31:0] FNV_PRIME = 32'h01000193;

    // power of two, so the queue pointers wrap on their own
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [31:0] hash_t;
    typedef logic [7:0]  count_t;

    typedef struct packed {
        logic  valid;
        hash_t hash;
    } hash_req_t;

    typedef struct packed {
        logic [QLVL_W-1:0] level;
        logic              full;
    } queue_stat_t;

    function automatic hash_t fnv_step(input hash_t h, input logic [7:0] b);
        hash_t x;
        x = h ^ {24'd0, b};
        return hash_t'(x * FNV_PRIME);
    endfunction

endpackage

// ----- sv/pdhc_ifs.sv -----
// Request channel interfaces: packet bytes in, lookup results out.
interface pdhc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       last_byte;

    modport source (output valid, output packet_byte, output last_byte, input ready);
    modport sink   (input valid, input packet_byte, input last_byte, output ready);
endinterface

interface pdhc_out_if;
    logic        valid;
    logic        ready;
    logic        is_duplicate;
    logic [31:0] hash_value;
    logic [7:0]  seen_count;

    modport source (output valid, output is_duplicate, output hash_value,
                    output seen_count, input ready);
    modport sink   (input valid, input is_duplicate, input hash_value,
                    input seen_count, output ready);
endinterface

// ----- sv/pdhc_front.sv -----
// Front end: folds each byte into the running FNV-1a hash, pushes finished hashes.
module pdhc_front
    import pdhc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    pdhc_in_if.sink     rx,
    input  queue_stat_t q_stat,
    output hash_req_t   push
);

    hash_t run_reg;
    hash_t run_next;
    hash_t step_hash;
    logic  take;

    assign rx.ready  = !q_stat.full;
    assign take      = rx.valid && rx.ready;
    assign step_hash = fnv_step(run_reg, rx.packet_byte);

    always_comb
    begin
        run_next = run_reg;
        if (take)
        begin
            run_next = rx.last_byte ? FNV_BASIS : step_hash;
        end
    end

    assign push.valid = take && rx.last_byte;
    assign push.hash  = step_hash;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= FNV_BASIS;
        end
        else
        begin
            run_reg <= run_next;
        end
    end

endmodule

// ----- sv/pdhc_queue.sv -----
// Short hash queue between the front end and the cache lookup.
module pdhc_queue
    import pdhc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  hash_req_t   push,
    output hash_req_t   head,
    input  logic        pop,
    output queue_stat_t stat
);

    hash_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QLVL_W-1:0] level_reg;
    logic [QLVL_W-1:0] level_next;
    logic              do_pop;

    assign do_pop = pop && (level_reg != '0);

    always_comb
    begin
        level_next = level_reg;
        if (push.valid && !do_pop)
        begin
            level_next = level_reg + QLVL_W'(1);
        end
        else if (!push.valid && do_pop)
        begin
            level_next = level_reg - QLVL_W'(1);
        end
    end

    assign head.valid = (level_reg != '0);
    assign head.hash  = slot_reg[rd_ptr_reg];
    assign stat.level = level_reg;
    assign stat.full  = (level_reg == QLVL_W'(QUEUE_DEPTH));

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            slot_reg[wr_ptr_reg] <= push.hash;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            level_reg <= level_next;
            if (push.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

endmodule

// ----- sv/pdhc_back.sv -----
// Back end: scans the hash cache, updates the hit or round-robin entry, emits a result.
module pdhc_back
    import pdhc_pkg::*;
#(
    parameter int CACHE_ENTRIES = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  hash_req_t  head,
    output logic       pop,
    pdhc_out_if.source res,
    output logic       busy
);

    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
    localparam int ENT_W = $bits(hash_t) + $bits(count_t);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [ENT_W-1:0]         mem [CACHE_ENTRIES];
    logic [CACHE_ENTRIES-1:0] vld_reg;
    logic [CNT_W-1:0]         rd_idx_reg;
    logic [CNT_W-1:0]         rd_idx_next;
    logic                     cmp_vld_reg;
    logic                     cmp_vld_next;
    logic [IDX_W-1:0]         cmp_idx_reg;
    logic [ENT_W-1:0]         rd_data_reg;
    logic                     rd_ent_vld_reg;
    logic [IDX_W-1:0]         ptr_reg;
    hash_t                    key_reg;
    logic                     hit_reg;
    logic [IDX_W-1:0]         hit_idx_reg;
    count_t                   cnt_reg;
    logic                     out_valid_reg;
    logic                     out_dup_reg;
    hash_t                    out_hash_reg;
    count_t                   out_cnt_reg;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic             mem_we;
    hash_t            seen_hash;
    count_t           seen_cnt;
    logic             match;
    logic             scan_end;
    logic             issue;
    logic             emit;

    assign rd_addr   = rd_idx_reg[IDX_W-1:0];
    assign issue     = (rd_idx_reg != CNT_W'(CACHE_ENTRIES));
    assign seen_hash = rd_ent_vld_reg ? rd_data_reg[ENT_W-1:$bits(count_t)] : '0;
    assign seen_cnt  = rd_ent_vld_reg ? rd_data_reg[$bits(count_t)-1:0] : '0;
    assign match     = cmp_vld_reg && (seen_hash == key_reg);
    assign scan_end  = cmp_vld_reg && (cmp_idx_reg == IDX_W'(CACHE_ENTRIES - 1));
    assign wr_addr   = hit_reg ? hit_idx_reg : ptr_reg;
    assign mem_we    = (state_reg == ST_UPDATE);
    assign emit      = (state_reg == ST_EMIT) && (!out_valid_reg || res.ready);
    assign pop       = (state_reg == ST_IDLE) && head.valid;
    assign busy      = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        rd_idx_next  = rd_idx_reg;
        cmp_vld_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                rd_idx_next = '0;
                if (head.valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (match || scan_end)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    cmp_vld_next = issue;
                    if (issue)
                    begin
                        rd_idx_next = rd_idx_reg + CNT_W'(1);
                    end
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg    <= mem[rd_addr];
        rd_ent_vld_reg <= vld_reg[rd_addr];
        cmp_idx_reg    <= rd_addr;
        if (mem_we)
        begin
            mem[wr_addr] <= {key_reg, cnt_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            key_reg <= head.hash;
            hit_reg <= 1'b0;
        end
        if (state_reg == ST_SCAN)
        begin
            if (match)
            begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= cmp_idx_reg;
                cnt_reg     <= seen_cnt + count_t'(1);
            end
            else if (scan_end)
            begin
                cnt_reg <= count_t'(1);
            end
        end
        if (emit)
        begin
            out_dup_reg  <= hit_reg;
            out_hash_reg <= key_reg;
            out_cnt_reg  <= cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_idx_reg    <= '0;
            cmp_vld_reg   <= 1'b0;
            vld_reg       <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_idx_reg  <= rd_idx_next;
            cmp_vld_reg <= cmp_vld_next;
            if (mem_we)
            begin
                vld_reg[wr_addr] <= 1'b1;
                if (!hit_reg)
                begin
                    ptr_reg <= (ptr_reg == IDX_W'(CACHE_ENTRIES - 1)) ?
                               '0 : ptr_reg + IDX_W'(1);
                end
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.is_duplicate = out_dup_reg;
    assign res.hash_value   = out_hash_reg;
    assign res.seen_count   = out_cnt_reg;

endmodule

// ----- sv/packet_dedup_hash_cache.sv -----
// Top level of the FNV-1a duplicate-packet cache.
// Bytes: one request per cycle while the hash queue has room; hashing adds no stall.
// Lookup time per packet is set by the one-read-per-cycle scan of the cache memory,
// which stops at the first hit; the queue hides it for long packets.
// Reset: running hash to the offset basis, queue empty, entry valid bits and pointer cleared.
`include "packet_dedup_hash_cache_macros.svh"

module packet_dedup_hash_cache
    import pdhc_pkg::*;
#(
    parameter int CACHE_ENTRIES = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    pdhc_in_if.sink    rx,
    pdhc_out_if.source res
);

    hash_req_t   push;
    hash_req_t   head;
    queue_stat_t q_stat;
    logic        pop;
    logic        back_busy;

    pdhc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx),
        .q_stat (q_stat),
        .push   (push)
    );

    pdhc_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .head  (head),
        .pop   (pop),
        .stat  (q_stat)
    );

    pdhc_back #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .res   (res),
        .busy  (back_busy)
    );

    `PDHC_ASSERT_NEXT(a_last_byte_queued, rx.valid && rx.ready && rx.last_byte, q_stat.level != '0)
    `PDHC_ASSERT_IMPL(a_result_from_lookup, $rose(res.valid), $past(back_busy))
    `PDHC_ASSERT_IMPL(a_miss_count_one, res.valid && !res.is_duplicate, res.seen_count == 8'd1)

endmodule

// ----- tb/sv/packet_dedup_hash_cache_tb.sv -----
// Testbench for the FNV-1a duplicate-packet cache: byte stimulus, lookup prediction, checking.
`timescale 1ns / 1ps

module packet_dedup_hash_cache_tb;
    import pdhc_pkg::*;

    localparam int     ENTRIES      = 16;
    localparam hash_t  FNV_SEED     = 32'h811c9dc5;
    localparam hash_t  FNV_MUL      = 32'h01000193;
    localparam int     ITEM_TARGET  = 800;
    localparam int     STREAK_LEN   = 258;
    localparam int     TPL_COUNT    = 24;
    localparam int     TPL_MAX      = 8;
    localparam int     DRAIN_CYCLES = 4 * (ENTRIES + 4);
    localparam int     LIMIT_CYCLES = 300000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       hold;
    } rx_item_t;

    typedef struct packed {
        logic   dup;
        hash_t  hash;
        count_t count;
    } lookup_t;

    logic clk = 1'b0;
    logic rst_n;

    pdhc_in_if  rx ();
    pdhc_out_if res ();

    packet_dedup_hash_cache #(.CACHE_ENTRIES(ENTRIES)) uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .res   (res)
    );

    rx_item_t   byte_q [$];
    lookup_t    lookup_q [$];

    hash_t      run_hash;
    hash_t      entry_hash  [ENTRIES];
    count_t     entry_count [ENTRIES];
    int         next_slot;

    logic [7:0] tpl_data [TPL_COUNT][TPL_MAX];
    int         tpl_len  [TPL_COUNT];

    int         err_count = 0;
    int         cycles = 0;
    int         gap_left;
    int         burst_left;
    logic [15:0] stall_pat;
    int         stall_tick;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic hash_t fnv_fold(input hash_t h, input logic [7:0] b);
        hash_t x;
        x = h ^ {24'd0, b};
        x = x * FNV_MUL;
        return x;
    endfunction

    function automatic void push_byte(input logic [7:0] b, input logic last, input logic hold);
        rx_item_t it;
        it.data = b;
        it.last = last;
        it.hold = hold;
        byte_q.push_back(it);
    endfunction

    function automatic void add_template(input int t, input logic hold);
        for (int k = 0; k < tpl_len[t]; k++)
        begin
            push_byte(tpl_data[t][k], k == tpl_len[t] - 1, hold && k == 0);
        end
    endfunction

    // five-byte packet whose hash is zero: meet in the middle on the upper 24 bits
    function automatic void add_zero_hash_packet();
        logic [15:0] prefix_of [logic [23:0]];
        logic [15:0] pre;
        hash_t       h2;
        hash_t       x;
        hash_t       inv;
        logic        found;
        inv = FNV_MUL;
        repeat (5) inv = inv * (32'd2 - FNV_MUL * inv);
        found = 1'b0;
        for (int i = 0; i < 65536; i++)
        begin
            h2 = fnv_fold(fnv_fold(FNV_SEED, i[15:8]), i[7:0]);
            prefix_of[h2[31:8]] = i[15:0];
        end
        for (int j = 0; j < 65536 && !found; j++)
        begin
            x = {24'd0, j[15:8]} * inv;
            x = (x ^ {24'd0, j[7:0]}) * inv;
            if (prefix_of.exists(x[31:8]))
            begin
                pre = prefix_of[x[31:8]];
                h2  = fnv_fold(fnv_fold(FNV_SEED, pre[15:8]), pre[7:0]);
                push_byte(pre[15:8], 1'b0, 1'b0);
                push_byte(pre[7:0], 1'b0, 1'b0);
                push_byte(h2[7:0] ^ x[7:0], 1'b0, 1'b0);
                push_byte(j[7:0], 1'b0, 1'b0);
                push_byte(j[15:8], 1'b1, 1'b0);
                found = 1'b1;
            end
        end
    endfunction

    function automatic void predict_lookup(input logic [7:0] b, input logic last);
        hash_t   h;
        lookup_t r;
        int      hit_at;
        h = fnv_fold(run_hash, b);
        if (!last)
        begin
            run_hash = h;
            return;
        end
        run_hash = FNV_SEED;
        hit_at = -1;
        for (int i = 0; i < ENTRIES && hit_at < 0; i++)
        begin
            if (entry_hash[i] == h)
            begin
                hit_at = i;
            end
        end
        r.hash = h;
        if (hit_at >= 0)
        begin
            entry_count[hit_at] = entry_count[hit_at] + 8'd1;
            r.dup   = 1'b1;
            r.count = entry_count[hit_at];
        end
        else
        begin
            entry_hash[next_slot]  = h;
            entry_count[next_slot] = 8'd1;
            next_slot = (next_slot + 1) % ENTRIES;
            r.dup   = 1'b0;
            r.count = 8'd1;
        end
        lookup_q.push_back(r);
    endfunction

    function automatic void note_error(input string msg);
        if (err_count < 10)
        begin
            $display("%s", msg);
        end
        err_count++;
    endfunction

    // byte driver
    always @(posedge clk or negedge rst_n)
    begin : drive_bytes
        rx_item_t it;
        logic     next_valid;
        if (!rst_n)
        begin
            rx.valid       <= 1'b0;
            rx.packet_byte <= 8'd0;
            rx.last_byte   <= 1'b0;
            gap_left   = 0;
            burst_left = 0;
            run_hash   = FNV_SEED;
            next_slot  = 0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                entry_hash[i]  = '0;
                entry_count[i] = '0;
            end
        end
        else
        begin
            if (rx.valid && rx.ready)
            begin
                predict_lookup(rx.packet_byte, rx.last_byte);
            end
            next_valid = 1'b0;
            if (rx.valid && !rx.ready)
            begin
                next_valid = 1'b1;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (byte_q.size() > 0 && !(byte_q[0].hold && lookup_q.size() > 0))
            begin
                it = byte_q.pop_front();
                rx.packet_byte <= it.data;
                rx.last_byte   <= it.last;
                next_valid = 1'b1;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    burst_left = $urandom_range(1, 24);
                end
            end
            rx.valid <= next_valid;
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin : watch_results
        lookup_t want;
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            stall_pat  = 16'hFFFF;
            stall_tick = 0;
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (lookup_q.size() == 0)
                begin
                    note_error($sformatf("unexpected result: dup %0d hash %h count %0d",
                                         res.is_duplicate, res.hash_value, res.seen_count));
                end
                else
                begin
                    want = lookup_q.pop_front();
                    if (res.is_duplicate !== want.dup || res.hash_value !== want.hash ||
                        res.seen_count !== want.count)
                    begin
                        note_error($sformatf(
                            "mismatch: dup %0d/%0d hash %h/%h count %0d/%0d (exp/got)",
                            want.dup, res.is_duplicate, want.hash, res.hash_value,
                            want.count, res.seen_count));
                    end
                end
            end
            stall_tick++;
            if (stall_tick % 64 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       stall_pat = 16'hFFFF;
                    1:       stall_pat = 16'($urandom) | 16'h0001;
                    default: stall_pat = (16'($urandom) & 16'($urandom)) | 16'h0001;
                endcase
            end
            res.ready <= stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[15:1]};
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : stimulus
        int   len;
        logic hold;
        rst_n = 1'b0;

        // zero hash hits a cleared entry; later copy hits the lowest zero entry left
        add_zero_hash_packet();
        push_byte(8'h00, 1'b1, 1'b0);
        push_byte(8'hFF, 1'b1, 1'b0);
        push_byte(8'hFF, 1'b1, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'hAA, 1'b0, 1'b0);
        push_byte(8'h55, 1'b1, 1'b0);
        add_zero_hash_packet();
        push_byte(8'h55, 1'b0, 1'b0);
        push_byte(8'hAA, 1'b1, 1'b0);

        // one packet over and over: count runs past 255 and wraps
        for (int k = 0; k < STREAK_LEN; k++)
        begin
            push_byte(8'h5A, 1'b1, k == 0);
        end

        for (int t = 0; t < TPL_COUNT; t++)
        begin
            tpl_len[t] = $urandom_range(1, TPL_MAX);
            for (int k = 0; k < TPL_MAX; k++)
            begin
                tpl_data[t][k] = 8'($urandom_range(0, 255));
            end
        end

        hold = 1'b1;
        while (byte_q.size() < ITEM_TARGET)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                add_template($urandom_range(0, TPL_COUNT - 1), hold);
            end
            else
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                begin
                    push_byte(8'($urandom_range(0, 255)), k == len - 1, hold && k == 0);
                end
            end
            hold = ($urandom_range(0, 99) == 0);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (byte_q.size() != 0 || rx.valid || lookup_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (lookup_q.size() != 0)
        begin
            note_error($sformatf("%0d results never arrived", lookup_q.size()));
        end
        if (err_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
